FILE: design/skpq_pkg.sv
// ----------------------------------------------------------------------------
// skpq_pkg
// shared types, request and status codes for the sorted key priority queue
// ----------------------------------------------------------------------------
package skpq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int KEY_W        = 32;
  localparam int ITEM_W       = 32;
  localparam int ENTRY_W      = KEY_W + ITEM_W;
  localparam int COUNT_W      = 5;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  // request codes
  localparam logic [2:0] REQ_INS = 3'd0;
  localparam logic [2:0] REQ_PRE = 3'd1;
  localparam logic [2:0] REQ_APP = 3'd2;
  localparam logic [2:0] REQ_RMH = 3'd3;
  localparam logic [2:0] REQ_RMK = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [KEY_W-1:0] key_in;
    logic [ITEM_W-1:0]       item_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [ITEM_W-1:0]       item_out;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
  } out_item_t;

  // results of the shared key unit
  typedef struct packed {
    logic                    lt;
    logic                    eq;
    logic signed [KEY_W-1:0] inc;
    logic signed [KEY_W-1:0] dec;
  } alu_res_t;

endpackage

FILE: design/sorted_key_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_key_priority_queue
// bounded queue of (key, item) entries held in ascending signed key order
// ----------------------------------------------------------------------------
// latency, from the accepting edge to the edge that raises out_valid: one ram
//   entry is visited per pass through ST_RD (read), then ST_EV (evaluate);
//   an insert walks from the tail, a prepend visits every entry, removals
//   every entry from the head, an append only the tail; adds then write in
//   ST_PUT and ST_FIN parks the result; rejects and unused codes go to ST_FIN
// throughput: one item at a time; the next item is taken the cycle after the
//   result is parked in the output register, which out_stall can hold off
// reset: clears the entry count, the sequencer and the output valid; the
//   entry ram is not cleared and is only read below the entry count
// ----------------------------------------------------------------------------
module sorted_key_priority_queue import skpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // one-hot sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_EV   = 5'b00100,
    ST_PUT  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                  state_r,   state_nxt;
  logic [2:0]              req_r,     req_nxt;
  logic signed [KEY_W-1:0] key_r,     key_nxt;
  logic [ITEM_W-1:0]       item_r,    item_nxt;
  logic [CW-1:0]           cnt_r,     cnt_nxt;
  logic [CW-1:0]           idx_r,     idx_nxt;
  logic [AW-1:0]           put_pos_r, put_pos_nxt;
  logic signed [KEY_W-1:0] new_key_r, new_key_nxt;
  logic                    found_r,   found_nxt;
  logic signed [KEY_W-1:0] res_key_r, res_key_nxt;
  logic [ITEM_W-1:0]       res_item_r, res_item_nxt;
  logic [1:0]              res_stat_r, res_stat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r,  out_data_nxt;

  // ram and shared unit hookup
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic signed [KEY_W-1:0] rd_key;
  logic [ITEM_W-1:0]       rd_item;
  alu_res_t                alu;

  logic          full;
  logic          accept;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] cnt_dec;
  logic          match;

  assign rd_key  = ram_rdata[ENTRY_W-1:ITEM_W];
  assign rd_item = ram_rdata[ITEM_W-1:0];
  assign full    = (cnt_r == CAP_CNT);
  assign accept  = in_valid && !in_stall;
  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign cnt_dec = cnt_r - CW'(1);

  skpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // compares the request key against the entry being visited
  skpq_alu u_alu (
    .a   (key_r),
    .b   (rd_key),
    .res (alu)
  );

  // remove head takes the first entry seen, remove by key the first equal one
  assign match = (req_r == REQ_RMH) || alu.eq;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    put_pos_nxt   = put_pos_r;
    new_key_nxt   = new_key_r;
    found_nxt     = found_r;
    res_key_nxt   = res_key_r;
    res_item_nxt  = res_item_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_inc[AW-1:0];
    ram_wdata     = ram_rdata;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt      = in_data.req_type;
          key_nxt      = in_data.key_in;
          item_nxt     = in_data.item_in;
          found_nxt    = 1'b0;
          res_key_nxt  = '0;
          res_item_nxt = '0;
          res_stat_nxt = STAT_OK;
          new_key_nxt  = '0;
          put_pos_nxt  = '0;
          idx_nxt      = cnt_dec;
          state_nxt    = ST_FIN;
          case (in_data.req_type)
            REQ_INS, REQ_PRE, REQ_APP: begin
              if (in_data.req_type == REQ_INS) begin
                res_key_nxt = in_data.key_in;
                new_key_nxt = in_data.key_in;
              end
              if (full) begin
                res_stat_nxt = STAT_FULL;
              end else if (cnt_r == '0) begin
                // empty queue: straight to position zero
                state_nxt = ST_PUT;
              end else begin
                state_nxt = ST_RD;
              end
            end
            REQ_RMH, REQ_RMK: begin
              idx_nxt = '0;
              if (cnt_r == '0) begin
                res_stat_nxt = STAT_EMPTY;
              end else begin
                state_nxt = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RD: begin
        state_nxt = ST_EV;
      end

      ST_EV: begin
        case (req_r)
          REQ_INS: begin
            if (alu.lt) begin
              // entry moves one place toward the tail
              ram_we    = 1'b1;
              ram_waddr = idx_inc[AW-1:0];
              if (idx_r == '0) begin
                put_pos_nxt = '0;
                state_nxt   = ST_PUT;
              end else begin
                idx_nxt   = idx_dec;
                state_nxt = ST_RD;
              end
            end else begin
              // after any equal keys
              put_pos_nxt = idx_inc[AW-1:0];
              state_nxt   = ST_PUT;
            end
          end
          REQ_PRE: begin
            ram_we    = 1'b1;
            ram_waddr = idx_inc[AW-1:0];
            if (idx_r == '0) begin
              new_key_nxt = alu.dec;
              put_pos_nxt = '0;
              state_nxt   = ST_PUT;
            end else begin
              idx_nxt   = idx_dec;
              state_nxt = ST_RD;
            end
          end
          REQ_APP: begin
            new_key_nxt = alu.inc;
            put_pos_nxt = idx_inc[AW-1:0];
            state_nxt   = ST_PUT;
          end
          REQ_RMH, REQ_RMK: begin
            if (found_r) begin
              // close the gap left by the removed entry
              ram_we    = 1'b1;
              ram_waddr = idx_dec[AW-1:0];
            end else if (match) begin
              found_nxt    = 1'b1;
              res_key_nxt  = rd_key;
              res_item_nxt = rd_item;
            end
            if (idx_r == cnt_dec) begin
              state_nxt = ST_FIN;
              if (found_r || match) begin
                cnt_nxt = cnt_dec;
              end else begin
                res_key_nxt  = key_r;
                res_stat_nxt = STAT_NOTFOUND;
              end
            end else begin
              idx_nxt   = idx_inc;
              state_nxt = ST_RD;
            end
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end

      ST_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = put_pos_r;
        ram_wdata   = {new_key_r, item_r};
        cnt_nxt     = cnt_r + CW'(1);
        res_key_nxt = new_key_r;
        state_nxt   = ST_FIN;
      end

      ST_FIN: begin
        // park the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.key_out     = res_key_r;
          out_data_nxt.item_out    = res_item_r;
          out_data_nxt.status      = res_stat_r;
          out_data_nxt.entry_count = COUNT_W'(cnt_r);
          out_data_nxt.is_empty    = (cnt_r == '0);
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    put_pos_r  <= put_pos_nxt;
    new_key_r  <= new_key_nxt;
    found_r    <= found_nxt;
    res_key_r  <= res_key_nxt;
    res_item_r <= res_item_nxt;
    res_stat_r <= res_stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // only idle takes a new item
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupancy stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("entry count above capacity");

  // an accepted item holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accept");

  // count moves by at most one per request
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CW'(1) ||
                      cnt_r + CW'(1) == $past(cnt_r)))
    else $error("entry count jumped");

  // a new result only comes out of the finish step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish step");

endmodule

FILE: design/skpq_ram.sv
// ----------------------------------------------------------------------------
// skpq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module skpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/skpq_alu.sv
// ----------------------------------------------------------------------------
// skpq_alu
// shared key unit: signed compare, equality and saturating step
// ----------------------------------------------------------------------------
module skpq_alu import skpq_pkg::*; (
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output alu_res_t                res
);

  always_comb begin
    res.lt  = (a < b);
    res.eq  = (a == b);
    res.inc = (b == KEY_MAX) ? b : b + 32'sd1;
    res.dec = (b == KEY_MIN) ? b : b - 32'sd1;
  end

endmodule

FILE: tb/sorted_key_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_priority_queue_tb
// self-checking bench: a directed run over the empty, saturation, duplicate-key
// and unused-code cases, then random bursts that fill and drain the queue;
// every result is checked in order against a shadow copy of the sorted store
// ----------------------------------------------------------------------------
module sorted_key_priority_queue_tb;
  import skpq_pkg::*;

  localparam int CAP      = DEF_CAPACITY;
  localparam int N_RANDOM = 1600;

  // request codes the block ignores
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

  // idle-free windows, counted in items
  localparam int CALM_LO = 700;
  localparam int CALM_HI = 1000;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_e;

  typedef struct {
    in_item_t req;
    bit       wait_idle;  // hold this item back until no result is owed
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pending_t  pending_q[$];
  out_item_t owed_q[$];
  logic signed [KEY_W-1:0] recent_keys[$];

  // shadow of the sorted store
  logic signed [KEY_W-1:0] shadow_key [CAP];
  logic [ITEM_W-1:0]       shadow_item[CAP];
  int shadow_cnt = 0;

  int n_sent = 0;
  int n_results = 0;
  int n_mismatch = 0;

  sorted_key_priority_queue #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow store
  // ---------------------------------------------------------------------------
  function automatic void place_entry(int pos, logic signed [KEY_W-1:0] k,
                                      logic [ITEM_W-1:0] it);
    for (int i = shadow_cnt; i > pos; i--) begin
      shadow_key[i]  = shadow_key[i-1];
      shadow_item[i] = shadow_item[i-1];
    end
    shadow_key[pos]  = k;
    shadow_item[pos] = it;
    shadow_cnt++;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < shadow_cnt; i++) begin
      shadow_key[i]  = shadow_key[i+1];
      shadow_item[i] = shadow_item[i+1];
    end
    shadow_cnt--;
  endfunction

  // applies one request to the shadow store and returns the answer it owes
  function automatic out_item_t queue_apply(in_item_t rq);
    out_item_t r;
    int pos;
    logic signed [KEY_W-1:0] k;
    bit full;
    r = '0;
    full = shadow_cnt >= CAP;
    case (rq.req_type)
      REQ_INS: begin
        r.key_out = rq.key_in;
        if (full) begin
          r.status = STAT_FULL;
        end else begin
          // after any equal keys
          pos = 0;
          while (pos < shadow_cnt && shadow_key[pos] <= rq.key_in) pos++;
          place_entry(pos, rq.key_in, rq.item_in);
        end
      end
      REQ_PRE: begin
        if (full) begin
          r.status = STAT_FULL;
        end else begin
          if (shadow_cnt == 0) k = '0;
          else if (shadow_key[0] == KEY_MIN) k = KEY_MIN;
          else k = shadow_key[0] - 1;
          r.key_out = k;
          place_entry(0, k, rq.item_in);
        end
      end
      REQ_APP: begin
        if (full) begin
          r.status = STAT_FULL;
        end else begin
          if (shadow_cnt == 0) k = '0;
          else if (shadow_key[shadow_cnt-1] == KEY_MAX) k = KEY_MAX;
          else k = shadow_key[shadow_cnt-1] + 1;
          r.key_out = k;
          place_entry(shadow_cnt, k, rq.item_in);
        end
      end
      REQ_RMH: begin
        if (shadow_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.key_out  = shadow_key[0];
          r.item_out = shadow_item[0];
          drop_entry(0);
        end
      end
      REQ_RMK: begin
        if (shadow_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.key_out = rq.key_in;
          pos = 0;
          while (pos < shadow_cnt && shadow_key[pos] != rq.key_in) pos++;
          if (pos >= shadow_cnt) begin
            r.status = STAT_NOTFOUND;
          end else begin
            r.item_out = shadow_item[pos];
            drop_entry(pos);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(shadow_cnt);
    r.is_empty    = (shadow_cnt == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_req(logic [2:0] op, logic signed [KEY_W-1:0] k,
                         logic [ITEM_W-1:0] it, bit wait_idle = 1'b0);
    pending_t p;
    p.req.req_type = op;
    p.req.key_in   = k;
    p.req.item_in  = it;
    p.wait_idle    = wait_idle;
    pending_q.push_back(p);
  endtask

  // request mix leans toward filling or draining so both full and empty recur
  function automatic logic [2:0] pick_req(burst_e style);
    int r;
    r = $urandom_range(99);
    case (style)
      BURST_FILL: begin
        if (r < 35) return REQ_INS;
        if (r < 55) return REQ_PRE;
        if (r < 75) return REQ_APP;
        if (r < 85) return REQ_RMH;
        if (r < 95) return REQ_RMK;
      end
      BURST_DRAIN: begin
        if (r < 10) return REQ_INS;
        if (r < 15) return REQ_PRE;
        if (r < 20) return REQ_APP;
        if (r < 60) return REQ_RMH;
        if (r < 95) return REQ_RMK;
      end
      default: begin
        if (r < 25) return REQ_INS;
        if (r < 37) return REQ_PRE;
        if (r < 49) return REQ_APP;
        if (r < 72) return REQ_RMH;
        if (r < 97) return REQ_RMK;
      end
    endcase
    return 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
  endfunction

  // small keys give duplicates and meet prepend/append keys, recent ones let
  // remove by key hit random entries
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 35) return KEY_W'($signed($urandom_range(6)) - 3);
    if (r < 50 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    if (r < 60) begin
      case ($urandom_range(3))
        0: return KEY_MIN;
        1: return KEY_MIN + 1;
        2: return KEY_MAX - 1;
        default: return KEY_MAX;
      endcase
    end
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // driver: takes the next item when the slot is free, idles at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    bit go;
    bit calm;
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_q.push_back(queue_apply(in_data));
        n_sent++;
      end
      // a stalled item stays put; otherwise pick what goes next
      if (!in_valid || !in_stall) begin
        calm = (n_sent >= CALM_LO && n_sent < CALM_HI);
        go = pending_q.size() != 0 && (calm || $urandom_range(99) >= 20);
        if (go && pending_q[0].wait_idle && owed_q.size() != 0) go = 1'b0;
        if (go) begin
          nxt = pending_q.pop_front();
          in_data  <= nxt.req;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result against the oldest owed answer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    out_item_t want;
    bit calm;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result: key %0d item %h status %0d count %0d empty %0b",
                     out_data.key_out, out_data.item_out, out_data.status,
                     out_data.entry_count, out_data.is_empty);
        end else begin
          want = owed_q.pop_front();
          if (out_data.key_out !== want.key_out || out_data.item_out !== want.item_out ||
              out_data.status !== want.status ||
              out_data.entry_count !== want.entry_count ||
              out_data.is_empty !== want.is_empty) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("result %0d mismatch", n_results);
              $display("  want key %0d item %h status %0d count %0d empty %0b",
                       want.key_out, want.item_out, want.status, want.entry_count,
                       want.is_empty);
              $display("  got  key %0d item %h status %0d count %0d empty %0b",
                       out_data.key_out, out_data.item_out, out_data.status,
                       out_data.entry_count, out_data.is_empty);
            end
          end
        end
        n_results++;
      end
      calm = (n_results >= CALM_LO && n_results < CALM_HI);
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t rq;
    burst_e style;
    int burst_left;
    int n_random;
    n_random = 0;
    burst_left = 0;
    style = BURST_MIXED;

    // empty queue: both removals report empty, prepend/append start at zero
    add_req(REQ_RMH, 32'sd0, 32'h0);
    add_req(REQ_RMK, 32'sd7, 32'h0);
    add_req(REQ_PRE, 32'sh5555_5555, 32'hAAAA_AAAA);
    add_req(REQ_RMH, 32'sd0, 32'h0);
    add_req(REQ_APP, 32'shAAAA_AAAA, 32'h5555_5555);
    add_req(REQ_APP, 32'sd0, 32'h1234_5678);
    add_req(REQ_PRE, 32'sd0, 32'h8765_4321);
    // saturation at both key limits
    add_req(REQ_INS, KEY_MAX, 32'hFFFF_FFFF);
    add_req(REQ_APP, 32'sd0, 32'h0000_0001);
    add_req(REQ_INS, KEY_MIN, 32'h0000_0000);
    add_req(REQ_PRE, 32'sd0, 32'h8000_0000);
    // equal keys: insert lands after, remove takes the one nearest the head
    add_req(REQ_INS, 32'sd5, 32'h0000_00A5);
    add_req(REQ_INS, 32'sd5, 32'h0000_00B5);
    add_req(REQ_RMK, 32'sd5, 32'h0);
    add_req(REQ_RMK, 32'sd12345, 32'h0);
    for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
      add_req(3'(c), $urandom(), $urandom());
    add_req(REQ_RMK, KEY_MAX, 32'h0);
    add_req(REQ_RMH, 32'sd0, 32'h0);

    // random bursts; every few hundred items the sender waits for a drain
    while (n_random < N_RANDOM) begin
      if (burst_left == 0) begin
        style = burst_e'($urandom_range(2));
        burst_left = $urandom_range(10, 40);
      end
      burst_left--;
      rq.req_type = pick_req(style);
      rq.key_in   = pick_key();
      rq.item_in  = $urandom();
      if (rq.req_type == REQ_INS) begin
        recent_keys.push_back(rq.key_in);
        if (recent_keys.size() > 8) void'(recent_keys.pop_front());
      end
      add_req(rq.req_type, rq.key_in, rq.item_in, (n_random % 400) == 0);
      if (rq.req_type <= REQ_RMK) n_random++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || owed_q.size() != 0);
    // let any stray result show up
    repeat (2 * CAP + 16) @(posedge clk);

    if (n_mismatch == 0) begin
      $display("** sorted_key_priority_queue: PASSED **");
    end else begin
      $display("** sorted_key_priority_queue: FAILED **");
    end
    $finish;
  end

  // generous bound on the whole run
  initial begin : watchdog
    #(5_000_000);
    $display("** sorted_key_priority_queue: FAILED **");
    $finish;
  end

endmodule
